FILE: hw/rtl/mh2_pkg.sv
// shared types and constants for the murmur2 32-bit stream hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mh2_pkg;

  localparam logic [31:0] MixMul    = 32'h5bd1e995;
  localparam int unsigned WordShift = 24;
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;

  localparam int unsigned MidDepthDefault = 4;
  localparam int unsigned OutDepthDefault = 4;

  typedef enum logic [1:0] {
    KindNone,
    KindWord,
    KindTail
  } mh2_kind_e;

  // one classified beat between front and back
  typedef struct packed {
    mh2_kind_e   kind;
    logic        first;
    logic        last;
    logic [31:0] len;
    logic [31:0] key;
  } mh2_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/murmur2_hash32_stream_top.sv
// 32-bit MurmurHash2 over a stream of little-endian words
// Input side is a queue: drive the beat fields with push_i, a beat is taken
// at a clock edge with push_i high and full_o low. Mark the first beat of a
// message with first_i (msg_length_i is sampled there) and the final beat
// with last_i. byte_count_i is 4 or more for a full word, 1 to 3 for the tail,
// 0 for no data. Result side is a queue too: while empty_o is low the oldest
// hash is on hash_value_o, and it leaves at an edge with pop_i high.
// Write the seed through cfg_we_i / cfg_hash_seed_i while the block is idle.
// Throughput: one beat per cycle while full_o is low, set by the single
// multiply-xor recurrence of the running hash in the back end; word
// premixing runs ahead in the front end. A stalled receiver fills the
// result queue (OutDepth hashes), then the mid queue (MidDepth beats), and
// full_o rises; nothing is lost.
// Reset clears the seed, the running hash and both queues.
// depends on mh2_pkg, mh2_fifo, mh2_front, mh2_back
`timescale 1ns / 1ps
`default_nettype none

module murmur2_hash32_stream_top #(
  parameter int unsigned MidDepth = mh2_pkg::MidDepthDefault,
  parameter int unsigned OutDepth = mh2_pkg::OutDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_hash_seed_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        first_i,
  input  wire logic        last_i,
  input  wire logic [31:0] msg_length_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [31:0]      hash_value_o
);

  import mh2_pkg::*;

  logic        mid_push, mid_pop, mid_empty;
  mh2_item_t   mid_in, mid_out;
  logic        out_push, out_pop;
  logic [31:0] out_data;

  assign out_pop = pop_i && !empty_o;

  mh2_front #(
    .MidDepth(MidDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .data_word_i (data_word_i),
    .byte_count_i(byte_count_i),
    .first_i     (first_i),
    .last_i      (last_i),
    .msg_length_i(msg_length_i),
    .mid_push_o  (mid_push),
    .mid_item_o  (mid_in),
    .mid_pop_i   (mid_pop)
  );

  mh2_fifo #(
    .Width($bits(mh2_item_t)),
    .Depth(MidDepth)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .din_i  (mid_in),
    .pop_i  (mid_pop),
    .dout_o (mid_out),
    .empty_o(mid_empty)
  );

  mh2_back #(
    .OutDepth(OutDepth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_hash_seed_i(cfg_hash_seed_i),
    .mid_empty_i    (mid_empty),
    .mid_item_i     (mid_out),
    .mid_pop_o      (mid_pop),
    .out_push_o     (out_push),
    .out_data_o     (out_data),
    .out_pop_i      (out_pop)
  );

  mh2_fifo #(
    .Width(32),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .din_i  (out_data),
    .pop_i  (out_pop),
    .dout_o (hash_value_o),
    .empty_o(empty_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mh2_fifo.sv
// small first-in first-out queue, flop array with combinational read
// depends on nothing; callers keep it from overflowing by credit
`timescale 1ns / 1ps
`default_nettype none

module mh2_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] din_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] dout_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;

  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mh2_front.sv
// front end: accepts input beats, classifies them and premixes full words
// depends on mh2_pkg; pushes into the mid queue, credit returned on back pops
`timescale 1ns / 1ps
`default_nettype none

module mh2_front #(
  parameter int unsigned MidDepth = mh2_pkg::MidDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  output logic                      full_o,
  input  wire logic [31:0]          data_word_i,
  input  wire logic [2:0]           byte_count_i,
  input  wire logic                 first_i,
  input  wire logic                 last_i,
  input  wire logic [31:0]          msg_length_i,
  output logic                      mid_push_o,
  output mh2_pkg::mh2_item_t        mid_item_o,
  input  wire logic                 mid_pop_i
);

  import mh2_pkg::*;

  localparam int unsigned CW = $clog2(MidDepth + 1);

  logic [CW-1:0] resv_q, resv_d;
  logic          accept;
  logic          s1_v_q, s2_v_q;
  mh2_item_t     s1_q, s1_d, s2_q, s2_d;
  logic [31:0]   tail_mask;
  logic [31:0]   k_shx;

  assign full_o = (resv_q == CW'(MidDepth));
  assign accept = push_i && !full_o;

  always_comb begin
    resv_d = resv_q;
    if (accept && !mid_pop_i) begin
      resv_d = resv_q + CW'(1);
    end else if (!accept && mid_pop_i) begin
      resv_d = resv_q - CW'(1);
    end
  end

  always_comb begin
    case (byte_count_i)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      default: tail_mask = 32'h00ff_ffff;
    endcase
  end

  // stage 1: classify, first multiply of a full word
  always_comb begin
    s1_d.first = first_i;
    s1_d.last  = last_i;
    s1_d.len   = msg_length_i;
    if (byte_count_i >= 3'd4) begin
      s1_d.kind = KindWord;
      s1_d.key  = data_word_i * MixMul;
    end else if (byte_count_i != 3'd0) begin
      s1_d.kind = KindTail;
      s1_d.key  = data_word_i & tail_mask;
    end else begin
      s1_d.kind = KindNone;
      s1_d.key  = '0;
    end
  end

  // stage 2: shift-xor and second multiply
  assign k_shx = s1_q.key ^ (s1_q.key >> WordShift);

  always_comb begin
    s2_d = s1_q;
    if (s1_q.kind == KindWord) begin
      s2_d.key = k_shx * MixMul;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resv_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      resv_q <= resv_d;
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  assign mid_push_o = s2_v_q;
  assign mid_item_o = s2_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mh2_back.sv
// back end: running hash recurrence, seed register and final mix
// depends on mh2_pkg; pulls from the mid queue, pushes into the result queue
`timescale 1ns / 1ps
`default_nettype none

module mh2_back #(
  parameter int unsigned OutDepth = mh2_pkg::OutDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [31:0]          cfg_hash_seed_i,
  input  wire logic                 mid_empty_i,
  input  wire mh2_pkg::mh2_item_t   mid_item_i,
  output logic                      mid_pop_o,
  output logic                      out_push_o,
  output logic [31:0]               out_data_o,
  input  wire logic                 out_pop_i
);

  import mh2_pkg::*;

  localparam int unsigned CW = $clog2(OutDepth + 1);

  logic [31:0]   seed_q;
  logic [31:0]   h_q, h_d;
  logic [CW-1:0] pend_q, pend_d;
  logic          issue, issue_last;
  logic [31:0]   base, mop, prod;
  logic          fin_v_q, mul_v_q;
  logic [31:0]   fin_h_q, mul_q, fin_x;

  // a last beat needs a reserved result slot
  assign issue = !mid_empty_i && (!mid_item_i.last || (pend_q != CW'(OutDepth)));
  assign issue_last = issue && mid_item_i.last;
  assign mid_pop_o  = issue;

  assign base = mid_item_i.first ? (seed_q ^ mid_item_i.len) : h_q;
  assign mop  = (mid_item_i.kind == KindTail) ? (base ^ mid_item_i.key) : base;
  assign prod = mop * MixMul;

  always_comb begin
    case (mid_item_i.kind)
      KindWord: h_d = prod ^ mid_item_i.key;
      KindTail: h_d = prod;
      default:  h_d = base;
    endcase
  end

  always_comb begin
    pend_d = pend_q;
    if (issue_last && !out_pop_i) begin
      pend_d = pend_q + CW'(1);
    end else if (!issue_last && out_pop_i) begin
      pend_d = pend_q - CW'(1);
    end
  end

  assign fin_x = fin_h_q ^ (fin_h_q >> FinShiftA);

  always_ff @(posedge clk_i) begin
    fin_h_q <= h_d;
    mul_q   <= fin_x * MixMul;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      h_q     <= '0;
      pend_q  <= '0;
      fin_v_q <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_hash_seed_i;
      end
      if (issue) begin
        h_q <= h_d;
      end
      pend_q  <= pend_d;
      fin_v_q <= issue_last;
      mul_v_q <= fin_v_q;
    end
  end

  assign out_push_o = mul_v_q;
  assign out_data_o = mul_q ^ (mul_q >> FinShiftB);

endmodule

`default_nettype wire

FILE: test/murmur2_hash32_stream_top_tb.sv
// self-checking bench for murmur2_hash32_stream_top: directed table, then random messages
// hashes are predicted by an in-bench murmur2 model and checked in order on the result queue
// depends on murmur2_hash32_stream_top and the rtl it pulls in
`timescale 1ns / 1ps

module murmur2_hash32_stream_top_tb;

  localparam logic [31:0] MurmurMul  = 32'h5bd1e995;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned PhaseBeats = 220;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned NumRows    = 23;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        first;
    logic        last;
    logic [31:0] len;
  } hash_beat_t;

  typedef struct packed {
    logic        seed_wr;
    logic [31:0] seed;
    hash_beat_t  beat;
    logic        typed;
    logic [31:0] hash;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_hash_seed_i = '0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [31:0] data_word_i = '0;
  logic [2:0]  byte_count_i = '0;
  logic        first_i = 1'b0;
  logic        last_i = 1'b0;
  logic [31:0] msg_length_i = '0;
  logic        empty_o;
  logic        pop_i = 1'b0;
  logic [31:0] hash_value_o;

  logic [31:0] seed_model = '0;
  logic [31:0] hash_state = '0;
  logic [31:0] pending_hashes[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned pop_stall_left = 0;
  bit          send_idle_on = 1'b1;
  bit          pop_idle_on = 1'b1;

  dir_row_t    dir_rows [NumRows];

  murmur2_hash32_stream_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_hash_seed_i(cfg_hash_seed_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .data_word_i    (data_word_i),
    .byte_count_i   (byte_count_i),
    .first_i        (first_i),
    .last_i         (last_i),
    .msg_length_i   (msg_length_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .hash_value_o   (hash_value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] murmur_word(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] km;
    km = k * MurmurMul;
    km = km ^ (km >> 24);
    km = km * MurmurMul;
    return (h * MurmurMul) ^ km;
  endfunction

  function automatic logic [31:0] murmur_tail(input logic [31:0] h, input logic [31:0] w,
                                              input logic [2:0] n);
    logic [31:0] mask;
    case (n)
      3'd1: mask = 32'h0000_00ff;
      3'd2: mask = 32'h0000_ffff;
      default: mask = 32'h00ff_ffff;
    endcase
    return (h ^ (w & mask)) * MurmurMul;
  endfunction

  function automatic logic [31:0] murmur_finish(input logic [31:0] h);
    logic [31:0] f;
    f = h ^ (h >> 13);
    f = f * MurmurMul;
    return f ^ (f >> 15);
  endfunction

  function automatic int unsigned gap_len(input bit on, input int unsigned long_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  // result side: check accepted hashes, then pick the next pop
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (pending_hashes.size() == 0) begin
          mismatch_count++;
          $display("%0t: hash_value expected none got %08h", $time, hash_value_o);
        end else begin
          if (hash_value_o !== pending_hashes[0]) begin
            mismatch_count++;
            $display("%0t: hash_value expected %08h got %08h", $time, pending_hashes[0],
                     hash_value_o);
          end
          void'(pending_hashes.pop_front());
        end
      end
      if (pop_stall_left != 0) begin
        pop_i <= 1'b0;
        pop_stall_left--;
      end else begin
        pop_i <= 1'b1;
        pop_stall_left = gap_len(pop_idle_on, 60);
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  task automatic pause_send(input int unsigned n);
    if (n != 0) begin
      push_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_beat(input hash_beat_t b, input logic typed, input logic [31:0] typed_hash);
    data_word_i  <= b.word;
    byte_count_i <= b.count;
    first_i      <= b.first;
    last_i       <= b.last;
    msg_length_i <= b.len;
    push_i       <= 1'b1;
    do @(posedge clk_i); while (full_o);
    if (b.first) hash_state = seed_model ^ b.len;
    if (b.count >= 3'd4) hash_state = murmur_word(hash_state, b.word);
    else if (b.count != 3'd0) hash_state = murmur_tail(hash_state, b.word, b.count);
    if (b.last) pending_hashes.push_back(typed ? typed_hash : murmur_finish(hash_state));
  endtask

  task automatic drain(input int unsigned extra);
    if (pending_hashes.size() != 0 || extra != 0) begin
      push_i <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clk_i);
      repeat (extra) @(posedge clk_i);
    end
  endtask

  task automatic write_seed(input logic [31:0] v);
    drain(DrainWait);
    cfg_hash_seed_i <= v;
    cfg_we_i        <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    seed_model = v;
    @(posedge clk_i);
  endtask

  // one message, mostly well formed; sometimes cut short or with a wrong length
  task automatic send_message(output int unsigned beats);
    int unsigned nwords;
    int unsigned tail;
    int unsigned r;
    bit          cut;
    hash_beat_t  b;
    logic [31:0] len;
    r = $urandom_range(0, 99);
    if (r < 80) nwords = $urandom_range(0, 6);
    else if (r < 97) nwords = $urandom_range(7, 16);
    else nwords = $urandom_range(17, 48);
    tail  = $urandom_range(0, 3);
    cut   = ($urandom_range(0, 19) == 0);
    len   = ($urandom_range(0, 9) == 0) ? $urandom : 32'(4 * nwords + tail);
    beats = 0;
    if (nwords == 0 && tail == 0) begin
      b = '{word: $urandom, count: 3'd0, first: 1'b1, last: !cut, len: len};
      send_beat(b, 1'b0, '0);
      beats = 1;
    end
    for (int unsigned i = 0; i < nwords; i++) begin
      b.word  = $urandom;
      b.count = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
      b.first = (i == 0);
      b.last  = (i == nwords - 1) && (tail == 0) && !cut;
      b.len   = len;
      send_beat(b, 1'b0, '0);
      beats++;
      pause_send(gap_len(send_idle_on, 40));
    end
    if (tail != 0) begin
      b = '{word: $urandom, count: 3'(tail), first: (nwords == 0), last: !cut, len: len};
      send_beat(b, 1'b0, '0);
      beats++;
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned got;
    hash_beat_t  b;
    logic [31:0] seed;

    dir_rows = '{
      '{1'b1, 32'h0000_0000, '{32'hdead_beef, 3'd0, 1'b1, 1'b1, 32'h0}, 1'b1, 32'h0},
      '{1'b0, 32'h0, '{32'h0000_0000, 3'd0, 1'b0, 1'b1, 32'h0}, 1'b1, 32'h0},
      '{1'b0, 32'h0, '{32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'd4}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'd8}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'hffff_ffff, 3'd4, 1'b0, 1'b1, 32'd0}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'd1}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'hffff_ffff, 3'd2, 1'b1, 1'b1, 32'd2}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'd3}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'h1234_5678, 3'd5, 1'b1, 1'b0, 32'd12}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'h89ab_cdef, 3'd6, 1'b0, 1'b0, 32'd0}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'hfedc_ba98, 3'd7, 1'b0, 1'b1, 32'd0}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'ha5a5_a5a5, 3'd2, 1'b1, 1'b0, 32'd9}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'h5a5a_5a5a, 3'd4, 1'b0, 1'b0, 32'd0}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'h0000_0000, 3'd0, 1'b0, 1'b0, 32'd0}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'hc3c3_c3c3, 3'd3, 1'b0, 1'b1, 32'd0}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'h1111_1111, 3'd4, 1'b0, 1'b1, 32'd0}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'h2222_2222, 3'd4, 1'b1, 1'b0, 32'd100}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'h3333_3333, 3'd4, 1'b1, 1'b1, 32'd4}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'hffff_ffff}, 1'b0, 32'h0},
      '{1'b1, 32'hffff_ffff, '{32'h0, 3'd0, 1'b1, 1'b1, 32'hffff_ffff}, 1'b1, 32'h0},
      '{1'b0, 32'h0, '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0}, 1'b0, 32'h0},
      '{1'b0, 32'h0, '{32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'hffff_ffff}, 1'b0, 32'h0},
      '{1'b1, 32'h8000_0000, '{32'h0000_0080, 3'd1, 1'b1, 1'b1, 32'd1}, 1'b0, 32'h0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (dir_rows[i].seed_wr) write_seed(dir_rows[i].seed);
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].hash);
      pause_send(gap_len(1'b1, 20));
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: seed = 32'hffff_ffff;
        1: seed = 32'h0000_0000;
        3: seed = 32'h0000_0001;
        default: seed = $urandom;
      endcase
      write_seed(seed);
      send_idle_on = (p[0] == 1'b0);
      pop_idle_on  = (p[1] == 1'b0);
      sent = 0;
      while (sent < PhaseBeats) begin
        if ($urandom_range(0, 99) < 85) begin
          send_message(got);
          sent += got;
        end else begin
          b.word  = $urandom;
          b.count = 3'($urandom_range(0, 7));
          b.first = 1'($urandom_range(0, 1));
          b.last  = 1'($urandom_range(0, 1));
          b.len   = $urandom;
          send_beat(b, 1'b0, '0);
          sent++;
        end
        // sender holds off until every pending hash is out
        if (p == 2 && sent >= PhaseBeats / 2 && sent < PhaseBeats / 2 + 8) drain(0);
        pause_send(gap_len(send_idle_on, 40));
      end
    end

    drain(20);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: murmur2_hash32_stream_top.f
hw/rtl/mh2_pkg.sv
hw/rtl/mh2_fifo.sv
hw/rtl/mh2_front.sv
hw/rtl/mh2_back.sv
hw/rtl/murmur2_hash32_stream_top.sv
test/murmur2_hash32_stream_top_tb.sv
